>>> rtl/iou_duplicate_detection_filter_assert.svh
// Assertion macros for the IoU duplicate detection filter.
// Each macro samples on clk and is disabled while rst_n is low; both must be in scope.
`ifndef IOU_DUPLICATE_DETECTION_FILTER_ASSERT_SVH
`define IOU_DUPLICATE_DETECTION_FILTER_ASSERT_SVH

// cond holds at every sampled edge
`define IDDF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define IDDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define IDDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iddf_pkg.sv
// Shared types, constants and box arithmetic helpers for the IoU duplicate detection filter.
// No dependencies.
`timescale 1ns / 1ps

package iddf_pkg;

  localparam int COORD_W  = 16;
  localparam int CLASS_W  = 8;
  localparam int SCORE_W  = 17;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int MATCH_W  = 7;
  localparam int COUNT_W  = 8;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int UNION_W  = AREA_W + 2;
  localparam int ENTRY_W  = 4 * COORD_W + CLASS_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Word index of the threshold register in paddr[CFG_ADDR_W-1:2]
  localparam logic [CFG_ADDR_W-3:0] REG_THRESHOLD = '0;
  localparam logic [SCORE_W-1:0]    THRESH_RESET  = 17'd32768;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0]  area_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD  = 2'd0,
    OP_TEST = 2'd1,
    OP_EOS  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED     = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_KEPT       = 3'd2,
    STAT_SUPPRESSED = 3'd3,
    STAT_BELOW      = 3'd4,
    STAT_CLEARED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_AREA,
    S_WALK,
    S_DRAIN,
    S_RESP
  } state_t;

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // Length from lo to hi, zero when hi does not lie above lo; fits 16 bits unsigned
  function automatic coord_t span(input coord_t lo, input coord_t hi);
    logic [COORD_W:0] diff;
    diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    return ($signed(hi) > $signed(lo)) ? diff[COORD_W-1:0] : '0;
  endfunction

endpackage

>>> rtl/iddf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iddf_ram #(
  parameter  int WIDTH = 72,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/iou_duplicate_detection_filter.sv
// Reference box store with IoU >= 0.5 duplicate suppression. An add word passes through
// accept and response; an end-of-sample word likewise. A detection word passes through
// accept, the span and area of its own box, the walk over the reference memory at one
// read per cycle (skipped with an empty store), the drain of the read/span/product stages
// that settles the first match, and the response.
// A result that is still stalled in the output register holds the next one in its response
// cycle. The next input word is taken while a result still waits in the output register.
// The store needs no clearing pass:
// the fill count alone marks which entries are live, and end of sample resets it.
`timescale 1ns / 1ps
`include "iou_duplicate_detection_filter_assert.svh"

module iou_duplicate_detection_filter #(
  parameter int MAX_REFS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [iddf_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic signed [iddf_pkg::COORD_W-1:0] in_box_left,
  input  logic signed [iddf_pkg::COORD_W-1:0] in_box_top,
  input  logic signed [iddf_pkg::COORD_W-1:0] in_box_right,
  input  logic signed [iddf_pkg::COORD_W-1:0] in_box_bottom,
  input  logic [iddf_pkg::CLASS_W-1:0]       in_class_label,
  input  logic [iddf_pkg::SCORE_W-1:0]       in_detection_score,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [iddf_pkg::STATUS_W-1:0]      out_status,
  output logic [iddf_pkg::MATCH_W-1:0]       out_match_index,
  output logic [iddf_pkg::COUNT_W-1:0]       out_reference_count,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iddf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [iddf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [iddf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  import iddf_pkg::*;

  localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CNT_W = $clog2(MAX_REFS + 1);

  // ---------------------------------------------------------------- config
  logic [SCORE_W-1:0] thr_r;
  logic               cfg_hit;

  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? CFG_DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      thr_r <= pwdata[SCORE_W-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ram_we, ram_re, load_det, load_out;

  // detection operand
  coord_t             det_l_r, det_t_r, det_rt_r, det_b_r;
  logic [CLASS_W-1:0] det_cls_r;
  logic [SCORE_W-1:0] det_score_r;
  coord_t             det_w_r, det_h_r;
  area_t              det_area_r;

  // compare pipeline
  logic [ENTRY_W-1:0] ram_rdata;
  logic               rd_v_r;
  logic [IDX_W-1:0]   rd_v_idx_r;
  logic               s2_v_r, s2_cls_eq_r;
  logic [IDX_W-1:0]   s2_idx_r;
  coord_t             s2_iw_r, s2_ih_r, s2_rw_r, s2_rh_r;
  logic               s3_v_r, s3_cls_eq_r;
  logic [IDX_W-1:0]   s3_idx_r;
  area_t              s3_inter_r, s3_rarea_r;
  logic               s3_hit;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    load_det       = 1'b0;
    load_out       = 1'b0;

    // keep only the first matching slot
    if (s3_v_r && s3_hit && !found_r) begin
      found_nxt     = 1'b1;
      found_idx_nxt = s3_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(in_opcode))
            OP_ADD: begin
              if (cnt_r < CNT_W'(MAX_REFS)) begin
                ram_we         = 1'b1;
                cnt_nxt        = cnt_r + CNT_W'(1);
                res_status_nxt = STAT_STORED;
              end else begin
                res_status_nxt = STAT_FULL;
              end
              state_nxt = S_RESP;
            end
            OP_TEST: begin
              load_det   = 1'b1;
              found_nxt  = 1'b0;
              rd_idx_nxt = '0;
              state_nxt  = S_SPAN;
            end
            default: begin
              // bit 1 set: end of sample
              cnt_nxt        = '0;
              res_status_nxt = STAT_CLEARED;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_SPAN: state_nxt = S_AREA;
      S_AREA: state_nxt = (cnt_r != '0) ? S_WALK : S_DRAIN;
      S_WALK: begin
        ram_re = 1'b1;
        if (rd_idx_r + CNT_W'(1) == cnt_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !s2_v_r && !s3_v_r) begin
          priority if (found_r) begin
            res_status_nxt = STAT_SUPPRESSED;
          end else if (det_score_r < thr_r) begin
            res_status_nxt = STAT_BELOW;
          end else begin
            res_status_nxt = STAT_KEPT;
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= ram_re;
      s2_v_r      <= rd_v_r;
      s3_v_r      <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    found_idx_r  <= found_idx_nxt;
    res_status_r <= res_status_nxt;
  end

  // ---------------------------------------------------------------- store
  // Writes happen only in IDLE and reads only during the walk, so no entry is
  // read and written in the same window.
  iddf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REFS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_class_label, in_box_bottom, in_box_right, in_box_top, in_box_left}),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- detection operand
  always_ff @(posedge clk) begin
    if (load_det) begin
      det_l_r     <= in_box_left;
      det_t_r     <= in_box_top;
      det_rt_r    <= in_box_right;
      det_b_r     <= in_box_bottom;
      det_cls_r   <= in_class_label;
      det_score_r <= in_detection_score;
    end
    if (state_r == S_SPAN) begin
      det_w_r <= span(det_l_r, det_rt_r);
      det_h_r <= span(det_t_r, det_b_r);
    end
    if (state_r == S_AREA) begin
      det_area_r <= det_w_r * det_h_r;
    end
  end

  // ---------------------------------------------------------------- compare pipeline
  coord_t             ref_l, ref_t, ref_r, ref_b;
  logic [CLASS_W-1:0] ref_cls;

  assign ref_l   = ram_rdata[0*COORD_W +: COORD_W];
  assign ref_t   = ram_rdata[1*COORD_W +: COORD_W];
  assign ref_r   = ram_rdata[2*COORD_W +: COORD_W];
  assign ref_b   = ram_rdata[3*COORD_W +: COORD_W];
  assign ref_cls = ram_rdata[4*COORD_W +: CLASS_W];

  always_ff @(posedge clk) begin
    rd_v_idx_r  <= rd_idx_r[IDX_W-1:0];
    // stage 2: spans of the overlap and of the reference box
    s2_idx_r    <= rd_v_idx_r;
    s2_cls_eq_r <= (ref_cls == det_cls_r);
    s2_iw_r     <= span(smax(det_l_r, ref_l), smin(det_rt_r, ref_r));
    s2_ih_r     <= span(smax(det_t_r, ref_t), smin(det_b_r, ref_b));
    s2_rw_r     <= span(ref_l, ref_r);
    s2_rh_r     <= span(ref_t, ref_b);
    // stage 3: areas
    s3_idx_r    <= s2_idx_r;
    s3_cls_eq_r <= s2_cls_eq_r;
    s3_inter_r  <= s2_iw_r * s2_ih_r;
    s3_rarea_r  <= s2_rw_r * s2_rh_r;
  end

  // IoU >= 1/2 as union > 0 and 2 * intersection >= union
  logic signed [UNION_W-1:0] uni, inter2;

  assign uni    = $signed(UNION_W'(det_area_r)) + $signed(UNION_W'(s3_rarea_r))
                - $signed(UNION_W'(s3_inter_r));
  assign inter2 = $signed({1'b0, s3_inter_r, 1'b0});
  assign s3_hit = s3_cls_eq_r && (uni > 0) && (inter2 >= uni);

  // ---------------------------------------------------------------- result register
  logic [STATUS_W-1:0] out_status_r;
  logic [MATCH_W-1:0]  out_match_index_r;
  logic [COUNT_W-1:0]  out_reference_count_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r          <= res_status_r;
      out_match_index_r     <= (res_status_r == STAT_SUPPRESSED) ?
                               MATCH_W'(found_idx_r) : '0;
      out_reference_count_r <= COUNT_W'(cnt_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_match_index     = out_match_index_r;
  assign out_reference_count = out_reference_count_r;

  // ---------------------------------------------------------------- assertions
  `IDDF_ASSERT_ALWAYS(a_count_bound, cnt_r <= CNT_W'(MAX_REFS), "fill count above store depth")
  `IDDF_ASSERT_NEXT(a_add_count, in_valid && !in_stall && in_opcode == OP_ADD && cnt_r < CNT_W'(MAX_REFS), cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1)), "stored box not counted")
  `IDDF_ASSERT_IMPL(a_match_range, state_r == S_RESP && res_status_r == STAT_SUPPRESSED, CNT_W'(found_idx_r) < cnt_r, "match slot outside live entries")
  `IDDF_ASSERT_IMPL(a_pipe_in_walk, s3_v_r || s2_v_r, state_r == S_WALK || state_r == S_DRAIN, "compare pipeline busy outside detection walk")

endmodule

>>> test/tb_iou_duplicate_detection_filter.sv
// Self-checking testbench for the IoU duplicate detection filter: a directed table, then
// random samples of reference and detection words under several idle/stall mixes.
// Depends on iddf_pkg and the iou_duplicate_detection_filter RTL.
`timescale 1ns / 1ps

module tb_iou_duplicate_detection_filter;
  import iddf_pkg::*;

  localparam int STORE_DEPTH = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 350;
  // bit 1 set decodes as end of sample
  localparam logic [OPCODE_W-1:0] OP_EOS_ALIAS = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [CLASS_W-1:0]        cls;
    logic [SCORE_W-1:0]        score;
  } box_word_t;

  typedef struct {
    status_t            status;
    logic [MATCH_W-1:0] match_idx;
    logic [COUNT_W-1:0] ref_count;
  } verdict_t;

  typedef struct {
    box_word_t w;
    bit        typed_in;
    verdict_t  v;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        in_opcode = '0;
  logic signed [COORD_W-1:0]  in_box_left = '0;
  logic signed [COORD_W-1:0]  in_box_top = '0;
  logic signed [COORD_W-1:0]  in_box_right = '0;
  logic signed [COORD_W-1:0]  in_box_bottom = '0;
  logic [CLASS_W-1:0]         in_class_label = '0;
  logic [SCORE_W-1:0]         in_detection_score = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic [MATCH_W-1:0]         out_match_index;
  logic [COUNT_W-1:0]         out_reference_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  // predictor state
  box_word_t          ref_store [STORE_DEPTH];
  int                 ref_fill;
  logic [SCORE_W-1:0] keep_threshold;
  verdict_t           pending_verdicts [$];
  verdict_t           no_verdict;

  int errors = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  iou_duplicate_detection_filter #(
    .MAX_REFS(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_box_left(in_box_left),
    .in_box_top(in_box_top),
    .in_box_right(in_box_right),
    .in_box_bottom(in_box_bottom),
    .in_class_label(in_class_label),
    .in_detection_score(in_detection_score),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_match_index(out_match_index),
    .out_reference_count(out_reference_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint extent(longint lo, longint hi);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // IoU >= 0.5 as union > 0 and 2*intersection >= union
  function automatic bit iou_half(box_word_t a, box_word_t b);
    longint iw, ih, inter, area_a, area_b, uni;
    iw = extent(lmax(longint'(a.left), longint'(b.left)),
                lmin(longint'(a.right), longint'(b.right)));
    ih = extent(lmax(longint'(a.top), longint'(b.top)),
                lmin(longint'(a.bottom), longint'(b.bottom)));
    inter = iw * ih;
    area_a = extent(a.left, a.right) * extent(a.top, a.bottom);
    area_b = extent(b.left, b.right) * extent(b.top, b.bottom);
    uni = area_a + area_b - inter;
    return (uni > 0) && (2 * inter >= uni);
  endfunction

  function automatic verdict_t judge_word(box_word_t w);
    verdict_t v;
    bit       found;
    int       hit;
    int       i;
    v.status = STAT_STORED;
    v.match_idx = '0;
    found = 1'b0;
    hit = 0;
    if (w.opcode == OP_ADD) begin
      if (ref_fill >= STORE_DEPTH) begin
        v.status = STAT_FULL;
      end else begin
        ref_store[ref_fill] = w;
        ref_fill++;
      end
    end else if (w.opcode == OP_TEST) begin
      for (i = 0; i < ref_fill && !found; i++) begin
        if (ref_store[i].cls == w.cls && iou_half(w, ref_store[i])) begin
          found = 1'b1;
          hit = i;
        end
      end
      if (found) begin
        v.status = STAT_SUPPRESSED;
        v.match_idx = MATCH_W'(hit);
      end else if (w.score < keep_threshold) begin
        v.status = STAT_BELOW;
      end else begin
        v.status = STAT_KEPT;
      end
    end else begin
      ref_fill = 0;
      v.status = STAT_CLEARED;
    end
    v.ref_count = COUNT_W'(ref_fill);
    return v;
  endfunction

  function automatic dir_row_t mk_row(logic [OPCODE_W-1:0] op, int l, int t, int r, int b,
                                      int cls, int score, bit typed_in, status_t st,
                                      int idx, int cnt);
    dir_row_t row;
    row.w.opcode = op;
    row.w.left = COORD_W'(l);
    row.w.top = COORD_W'(t);
    row.w.right = COORD_W'(r);
    row.w.bottom = COORD_W'(b);
    row.w.cls = CLASS_W'(cls);
    row.w.score = SCORE_W'(score);
    row.typed_in = typed_in;
    row.v.status = st;
    row.v.match_idx = MATCH_W'(idx);
    row.v.ref_count = COUNT_W'(cnt);
    return row;
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(2))
      0: return -16'sd32768;
      1: return 16'sd32767;
      default: return '0;
    endcase
  endfunction

  function automatic box_word_t random_box(logic [CLASS_W-1:0] cls);
    box_word_t b;
    int        mode, x, y;
    b.opcode = OP_ADD;
    b.cls = cls;
    b.score = '0;
    mode = $urandom_range(99);
    if (mode < 6) begin
      b.left = COORD_W'($urandom);
      b.top = COORD_W'($urandom);
      b.right = COORD_W'($urandom);
      b.bottom = COORD_W'($urandom);
    end else if (mode < 15) begin
      b.left = extreme_coord();
      b.top = extreme_coord();
      b.right = extreme_coord();
      b.bottom = extreme_coord();
    end else begin
      x = int'($urandom_range(0, 8000)) - 4000;
      y = int'($urandom_range(0, 8000)) - 4000;
      b.left = COORD_W'(x);
      b.top = COORD_W'(y);
      b.right = COORD_W'(x + int'($urandom_range(0, 1200)));
      b.bottom = COORD_W'(y + int'($urandom_range(0, 1200)));
      // flip one axis now and then for a zero area
      if (mode < 22) b.right = COORD_W'(x - int'($urandom_range(1, 500)));
      if (mode >= 22 && mode < 26) b.bottom = COORD_W'(y - int'($urandom_range(0, 500)));
    end
    return b;
  endfunction

  function automatic box_word_t jitter_box(box_word_t b, int jmax);
    box_word_t j;
    j = b;
    j.left = COORD_W'(int'(b.left) + int'($urandom_range(0, 2 * jmax)) - jmax);
    j.top = COORD_W'(int'(b.top) + int'($urandom_range(0, 2 * jmax)) - jmax);
    j.right = COORD_W'(int'(b.right) + int'($urandom_range(0, 2 * jmax)) - jmax);
    j.bottom = COORD_W'(int'(b.bottom) + int'($urandom_range(0, 2 * jmax)) - jmax);
    return j;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int r, s;
    r = $urandom_range(99);
    if (r < 25) begin
      s = int'(keep_threshold) + int'($urandom_range(0, 4)) - 2;
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      return SCORE_W'(s);
    end else if (r < 35) begin
      return $urandom_range(1) ? SCORE_W'(65536) : '0;
    end
    return SCORE_W'($urandom_range(0, 65536));
  endfunction

  function automatic box_word_t noise_word();
    box_word_t w;
    w = random_box(CLASS_W'($urandom));
    w.left = COORD_W'($urandom);
    w.bottom = COORD_W'($urandom);
    w.opcode = OPCODE_W'($urandom);
    w.score = SCORE_W'($urandom_range(0, 65536));
    return w;
  endfunction

  task automatic send_word(box_word_t w, bit typed_in, verdict_t v);
    verdict_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= w.opcode;
    in_box_left <= w.left;
    in_box_top <= w.top;
    in_box_right <= w.right;
    in_box_bottom <= w.bottom;
    in_class_label <= w.cls;
    in_detection_score <= w.score;
    do @(posedge clk); while (in_stall);
    predicted = judge_word(w);
    pending_verdicts.push_back(typed_in ? v : predicted);
  endtask

  // drop valid, let every result drain, then cover the longest walk
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic set_threshold(logic [SCORE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESHOLD, 2'b00};
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    keep_threshold = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[SCORE_W-1:0] !== value) report_mismatch("threshold readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(int words, bit fill_first);
    int                 sent, adds_left, tests_left, n_cls, jmax, noise_pct;
    bit                 big, first;
    logic [CLASS_W-1:0] pool [3];
    box_word_t          made [$];
    box_word_t          w;
    sent = 0;
    first = 1'b1;
    while (sent < words) begin
      big = (first && fill_first) || ($urandom_range(99) < 2);
      first = 1'b0;
      adds_left = big ? $urandom_range(128, 134) : $urandom_range(0, 14);
      tests_left = big ? $urandom_range(2, 5) : $urandom_range(1, 16);
      noise_pct = big ? 0 : 8;
      n_cls = $urandom_range(1, 3);
      foreach (pool[k]) pool[k] = CLASS_W'($urandom);
      made.delete();
      while (adds_left > 0 || tests_left > 0) begin
        if ($urandom_range(99) < noise_pct) begin
          w = noise_word();
        end else if (tests_left == 0 || (adds_left > 0 && $urandom_range(1) == 1)) begin
          w = random_box(pool[$urandom_range(n_cls - 1)]);
          w.score = pick_score();
          made.push_back(w);
          adds_left--;
        end else begin
          if (made.size() > 0 && $urandom_range(99) < 70) begin
            case ($urandom_range(3))
              0: jmax = 0;
              1: jmax = 3;
              2: jmax = 40;
              default: jmax = 300;
            endcase
            w = jitter_box(made[$urandom_range(made.size() - 1)], jmax);
            if ($urandom_range(99) < 15) w.cls = pool[$urandom_range(n_cls - 1)];
          end else begin
            w = random_box(pool[$urandom_range(n_cls - 1)]);
          end
          w.opcode = OP_TEST;
          w.score = pick_score();
          tests_left--;
        end
        send_word(w, 1'b0, no_verdict);
        sent++;
      end
      w = noise_word();
      w.opcode = ($urandom_range(3) == 0) ? OP_EOS_ALIAS : OP_EOS;
      send_word(w, 1'b0, no_verdict);
      sent++;
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < snk_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_status, -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_match_index !== want.match_idx)
          report_mismatch("match_index", out_match_index, want.match_idx);
        if (out_reference_count !== want.ref_count)
          report_mismatch("reference_count", out_reference_count, want.ref_count);
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    no_verdict.status = STAT_STORED;
    no_verdict.match_idx = '0;
    no_verdict.ref_count = '0;
    ref_fill = 0;
    keep_threshold = THRESH_RESET;

    // empty store, score at and just below the reset threshold
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 160, 160, 5, 32768, 1, STAT_KEPT, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 160, 160, 5, 32767, 1, STAT_BELOW, 0, 0));
    dir_rows.push_back(mk_row(OP_ADD, 0, 0, 160, 160, 5, 0, 1, STAT_STORED, 0, 1));
    dir_rows.push_back(mk_row(OP_ADD, -32768, -32768, 32767, 32767, 255, 65536, 1,
                              STAT_STORED, 0, 2));
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 160, 160, 5, 0, 1, STAT_SUPPRESSED, 0, 2));
    // same box, other class
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 160, 160, 6, 65536, 1, STAT_KEPT, 0, 2));
    dir_rows.push_back(mk_row(OP_TEST, -32768, -32768, 32767, 32767, 255, 0, 1,
                              STAT_SUPPRESSED, 1, 2));
    // inverted boxes: zero areas, empty union
    dir_rows.push_back(mk_row(OP_ADD, 100, 100, 0, 0, 7, 0, 1, STAT_STORED, 0, 3));
    dir_rows.push_back(mk_row(OP_TEST, 100, 100, 0, 0, 7, 40000, 1, STAT_KEPT, 0, 3));
    dir_rows.push_back(mk_row(OP_ADD, 50, 50, 50, 90, 7, 0, 0, STAT_STORED, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 50, 50, 50, 90, 7, 0, 0, STAT_STORED, 0, 0));
    // IoU exactly one half, then just under
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 80, 160, 5, 0, 0, STAT_STORED, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 79, 160, 5, 0, 0, STAT_STORED, 0, 0));
    dir_rows.push_back(mk_row(OP_ADD, 0, 0, 160, 160, 5, 0, 0, STAT_STORED, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 2, 1, 161, 158, 5, 100, 0, STAT_STORED, 0, 0));
    dir_rows.push_back(mk_row(OP_EOS, 0, 0, 0, 0, 0, 0, 1, STAT_CLEARED, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 0, 0, 160, 160, 5, 32768, 1, STAT_KEPT, 0, 0));
    dir_rows.push_back(mk_row(OP_ADD, -32768, -32768, -32000, -32000, 0, 0, 1,
                              STAT_STORED, 0, 1));
    dir_rows.push_back(mk_row(OP_EOS_ALIAS, 1, 2, 3, 4, 9, 7, 1, STAT_CLEARED, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, -32768, -32768, -32000, -32000, 0, 0, 1,
                              STAT_BELOW, 0, 0));
    dir_rows.push_back(mk_row(OP_TEST, 32767, 32767, -32768, -32768, 0, 65536, 1,
                              STAT_KEPT, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed_in, dir_rows[i].v);
    wait_drain();

    set_threshold('0);
    run_phase(PHASE_WORDS, 1'b1);
    wait_drain();

    src_idle_pct = 85;
    set_threshold(SCORE_W'(65536));
    run_phase(PHASE_WORDS, 1'b0);
    wait_drain();

    src_idle_pct = 0;
    snk_stall_pct = 85;
    set_threshold(SCORE_W'($urandom_range(1, 65535)));
    run_phase(PHASE_WORDS, 1'b1);
    wait_drain();

    src_idle_pct = 13;
    snk_stall_pct = 13;
    set_threshold(THRESH_RESET);
    run_phase(PHASE_WORDS, 1'b0);
    wait_drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
